// ----- rtl/csvx_pkg.sv -----
// Package for the CSV column extractor: character codes, counter limits
// and the result beat type. No dependencies.
`default_nettype none

package csvx_pkg;

    localparam int unsigned COLUMN_W = 16;
    localparam int unsigned LENGTH_W = 24;
    localparam int unsigned BYTE_W   = 8;

    // Counters stop at these values; both equal the all-ones value of their width.
    localparam logic [COLUMN_W-1:0] COLUMN_CAP = 16'hFFFF;
    localparam logic [LENGTH_W-1:0] LENGTH_CAP = 24'hFFFFFF;

    localparam logic [BYTE_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CHAR_COMMA = 8'h2C;

    typedef struct packed {
        logic                line_done;
        logic [BYTE_W-1:0]   field_byte;
        logic [LENGTH_W-1:0] field_length;
        logic                length_saturated;
    } result_t;

endpackage

`default_nettype wire

// ----- rtl/csvx_parser.sv -----
// Line and column tracking for the CSV column extractor. Decides per input
// beat whether a result is produced. Depends on csvx_pkg.
`default_nettype none

module csvx_parser (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            cfg_we,
    input  wire [csvx_pkg::COLUMN_W-1:0]   cfg_wdata,
    input  wire                            accept,
    input  wire [csvx_pkg::BYTE_W-1:0]     data_byte,
    input  wire                            end_of_data,
    output logic                           res_valid,
    output csvx_pkg::result_t              res
);
    import csvx_pkg::*;

    logic [COLUMN_W-1:0] target_reg, target_next;
    logic                in_line_reg, in_line_next;
    logic [COLUMN_W-1:0] column_reg, column_next;
    logic [LENGTH_W-1:0] length_reg, length_next;
    logic                overflow_reg, overflow_next;

    logic                is_end;
    logic                start;
    logic [COLUMN_W-1:0] column_eff;
    logic [LENGTH_W-1:0] length_eff;
    logic                overflow_eff;

    assign is_end = end_of_data || (data_byte == CHAR_NUL) ||
                    (data_byte == CHAR_CR) || (data_byte == CHAR_LF);
    assign start  = !in_line_reg && !is_end && (data_byte != CHAR_SPACE);

    // A starting byte sees a freshly cleared line.
    assign column_eff   = start ? '0 : column_reg;
    assign length_eff   = start ? '0 : length_reg;
    assign overflow_eff = start ? 1'b0 : overflow_reg;

    always_comb
    begin
        target_next   = cfg_we ? cfg_wdata : target_reg;
        in_line_next  = in_line_reg;
        column_next   = column_reg;
        length_next   = length_reg;
        overflow_next = overflow_reg;
        res_valid     = 1'b0;
        res           = '0;
        if (accept)
        begin
            if (in_line_reg && is_end)
            begin
                res_valid             = 1'b1;
                res.line_done         = 1'b1;
                res.field_length      = length_reg;
                res.length_saturated  = overflow_reg;
                in_line_next          = 1'b0;
                column_next           = '0;
                length_next           = '0;
                overflow_next         = 1'b0;
            end
            else if (in_line_reg || start)
            begin
                in_line_next  = 1'b1;
                column_next   = column_eff;
                length_next   = length_eff;
                overflow_next = overflow_eff;
                if (data_byte == CHAR_COMMA)
                begin
                    if (column_eff < COLUMN_CAP)
                        column_next = column_eff + 1'b1;
                end
                else if (column_eff == target_reg)
                begin
                    if (length_eff < LENGTH_CAP)
                        length_next = length_eff + 1'b1;
                    else
                        overflow_next = 1'b1;
                    res_valid      = 1'b1;
                    res.field_byte = data_byte;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg   <= '0;
            in_line_reg  <= 1'b0;
            column_reg   <= '0;
            length_reg   <= '0;
            overflow_reg <= 1'b0;
        end
        else
        begin
            target_reg   <= target_next;
            in_line_reg  <= in_line_next;
            column_reg   <= column_next;
            length_reg   <= length_next;
            overflow_reg <= overflow_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/csvx_out_queue.sv -----
// Two-entry result queue for the CSV column extractor; decouples output
// stall from input stall. Depends on csvx_pkg.
`default_nettype none

module csvx_out_queue (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      push,
    input  wire csvx_pkg::result_t   push_data,
    output logic                     full,
    output logic                     out_valid,
    input  wire                      out_stall,
    output csvx_pkg::result_t        out_data
);
    import csvx_pkg::*;

    result_t     slot_reg [2];
    result_t     slot_next [2];
    logic [1:0]  count_reg, count_next;
    logic        pop;
    logic [1:0]  base;

    assign full      = (count_reg == 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = slot_reg[0];
    assign pop       = out_valid && !out_stall;
    assign base      = count_reg - {1'b0, pop};

    always_comb
    begin
        slot_next[0] = pop ? slot_reg[1] : slot_reg[0];
        slot_next[1] = slot_reg[1];
        if (push)
        begin
            if (base == 2'd0)
                slot_next[0] = push_data;
            else
                slot_next[1] = push_data;
        end
        count_next = base + {1'b0, push};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        slot_reg[0] <= slot_next[0];
        slot_reg[1] <= slot_next[1];
    end

endmodule

`default_nettype wire

// ----- rtl/csv_column_extractor.sv -----
// A result is registered in the result queue before it appears on the output; the parser itself is combinational.
// Throughput: one input beat per cycle unless the full result queue stalls the input; the
// line, column and length counters are updated together for each accepted beat, so the counter update sets the rate.
// A two-entry result queue keeps input stall registered and off the output stall path.
// Reset (rst_n, asynchronous, active low) clears the target column to zero,
// puts the parser between lines and empties the result queue.
`default_nettype none

module csv_column_extractor (
    input  wire                            clk,
    input  wire                            rst_n,
    // Configuration: target column, written whenever cfg_we is high.
    input  wire                            cfg_we,
    input  wire [csvx_pkg::COLUMN_W-1:0]   cfg_wdata,
    // Input channel: one text byte per beat.
    input  wire                            in_valid,
    output logic                           in_stall,
    input  wire [csvx_pkg::BYTE_W-1:0]     data_byte,
    input  wire                            end_of_data,
    // Output channel: a field byte or an end-of-line beat.
    output logic                           out_valid,
    input  wire                            out_stall,
    output logic                           line_done,
    output logic [csvx_pkg::BYTE_W-1:0]    field_byte,
    output logic [csvx_pkg::LENGTH_W-1:0]  field_length,
    output logic                           length_saturated
);
    import csvx_pkg::*;

    logic    accept;
    logic    res_valid;
    result_t res;
    result_t out_data;
    logic    queue_full;

    // An input beat is taken whenever the queue has a free entry. Each beat
    // produces at most one result, so a free entry is all that is needed.
    assign in_stall = queue_full;
    assign accept   = in_valid && !in_stall;

    // The parser holds the line state and the target column register. It
    // looks at the beat on the ports and decides, in the same cycle, whether
    // it yields a field byte, ends a line, or is simply consumed.
    csvx_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .accept      (accept),
        .data_byte   (data_byte),
        .end_of_data (end_of_data),
        .res_valid   (res_valid),
        .res         (res)
    );

    // Results are registered here; the head entry drives the output ports.
    csvx_out_queue u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .full      (queue_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign line_done        = out_data.line_done;
    assign field_byte       = out_data.field_byte;
    assign field_length     = out_data.field_length;
    assign length_saturated = out_data.length_saturated;

    // A full queue must be presenting a result.
    assert property (@(posedge clk) disable iff (!rst_n) in_stall |-> out_valid)
        else $error("input stalled while no result is offered");

    // A field byte beat carries no length information.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !line_done) |-> (field_length == '0 && !length_saturated))
        else $error("field byte beat carries a length");

    // An end-of-line beat carries no byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && line_done) |-> (field_byte == '0))
        else $error("end-of-line beat carries a byte");

    // A beat that was offered and not taken is still offered next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("stalled result was dropped");

endmodule

`default_nettype wire

// ----- bench/csv_column_extractor_test.sv -----
// Self-checking bench for csv_column_extractor: text beats go in, and the field-byte
// and end-of-line beats that come out are checked against a built-in line parser.
// Depends on csvx_pkg and the csv_column_extractor RTL only.
module csv_column_extractor_test;

    import csvx_pkg::*;

    // Watchdog limit; a correct run finishes within it even under heavy receiver stall.
    localparam int unsigned CYCLE_LIMIT = 40_000;
    // Settling time after the bench drains, so that a register write finds the block idle.
    localparam int unsigned SETTLE_CYCLES = 6;
    localparam int unsigned REPORT_LIMIT = 10;
    localparam int unsigned LONG_HOLD_CYCLES = 160;

    typedef struct packed {
        logic [BYTE_W-1:0] value;
        logic              eod;
    } text_beat_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic [COLUMN_W-1:0] cfg_wdata = '0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [BYTE_W-1:0]   data_byte = '0;
    logic                end_of_data = 1'b0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic                line_done;
    logic [BYTE_W-1:0]   field_byte;
    logic [LENGTH_W-1:0] field_length;
    logic                length_saturated;

    csv_column_extractor u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .data_byte        (data_byte),
        .end_of_data      (end_of_data),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .line_done        (line_done),
        .field_byte       (field_byte),
        .field_length     (field_length),
        .length_saturated (length_saturated)
    );

    // Beats waiting to be offered, and the results that accepted beats still owe us.
    text_beat_t pending_beats[$];
    result_t    field_results_due[$];

    // Parser state mirrored from the block, plus our copy of the target column.
    logic [COLUMN_W-1:0] target_now = '0;
    logic                line_open = 1'b0;
    logic [COLUMN_W-1:0] column_now = '0;
    logic [LENGTH_W-1:0] length_now = '0;
    logic                length_capped = 1'b0;

    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    int unsigned hold_requests = 0;
    int unsigned holds_served = 0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic note_error(input string msg);
        error_count++;
        if (error_count <= REPORT_LIMIT)
            $display("%s", msg);
    endtask

    // Walks one accepted text beat through the line parser and records the result
    // it owes, if any. Between lines, blanks and end marks are swallowed; inside a
    // line an end mark closes the line with its length, commas step the column,
    // and bytes of the selected column are passed on while the length counts up.
    function automatic void parse_text_beat(input logic [BYTE_W-1:0] value,
                                            input logic eod);
        result_t owed;
        logic    ends_line;
        ends_line = eod || value == CHAR_NUL || value == CHAR_CR || value == CHAR_LF;
        if (!line_open)
        begin
            if (ends_line || value == CHAR_SPACE)
                return;
            line_open = 1'b1;
            column_now = '0;
            length_now = '0;
            length_capped = 1'b0;
        end
        else if (ends_line)
        begin
            owed.line_done = 1'b1;
            owed.field_byte = '0;
            owed.field_length = length_now;
            owed.length_saturated = length_capped;
            field_results_due.push_back(owed);
            line_open = 1'b0;
            column_now = '0;
            length_now = '0;
            length_capped = 1'b0;
            return;
        end
        if (value == CHAR_COMMA)
        begin
            // Past the last countable column everything folds into that column.
            if (column_now != COLUMN_CAP)
                column_now = column_now + 1'b1;
            return;
        end
        if (column_now == target_now)
        begin
            if (length_now != LENGTH_CAP)
                length_now = length_now + 1'b1;
            else
                length_capped = 1'b1;
            owed.line_done = 1'b0;
            owed.field_byte = value;
            owed.field_length = '0;
            owed.length_saturated = 1'b0;
            field_results_due.push_back(owed);
        end
    endfunction

    // Sender: offers queued beats in bursts of random length with random gaps.
    // A beat that is stalled is held unchanged until the block takes it.
    int unsigned burst_left = 1;
    int unsigned gap_left = 0;

    always @(posedge clk)
    begin
        text_beat_t next_beat;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            data_byte <= '0;
            end_of_data <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                parse_text_beat(data_byte, end_of_data);
            if (!in_valid || !in_stall)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_beats.size() != 0)
                begin
                    next_beat = pending_beats.pop_front();
                    in_valid <= 1'b1;
                    data_byte <= next_beat.value;
                    end_of_data <= next_beat.eod;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 24);
                        // About a quarter of bursts run straight into the next one.
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                    begin
                        burst_left--;
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver stall pattern: it switches between no stall, light random stall,
    // alternate cycles and heavy stall, and serves requests for a long hold.
    int unsigned stall_mode = 0;
    int unsigned mode_left = 0;
    int unsigned hold_left = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else if (hold_requests != holds_served)
        begin
            holds_served <= hold_requests;
            hold_left = LONG_HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 200);
            end
            else
            begin
                mode_left--;
            end
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                2: out_stall <= ~out_stall;
                default: out_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // Checker: every accepted output beat must match the oldest owed result.
    always @(posedge clk)
    begin
        result_t owed;
        if (rst_n && out_valid && !out_stall)
        begin
            if (field_results_due.size() == 0)
            begin
                note_error($sformatf("unexpected beat: done=%0b byte=%h len=%0d sat=%0b",
                    line_done, field_byte, field_length, length_saturated));
            end
            else
            begin
                owed = field_results_due.pop_front();
                if (line_done !== owed.line_done || field_byte !== owed.field_byte ||
                    field_length !== owed.field_length ||
                    length_saturated !== owed.length_saturated)
                    note_error($sformatf(
                        {"mismatch: want done=%0b byte=%h len=%0d sat=%0b, ",
                         "got done=%0b byte=%h len=%0d sat=%0b"},
                        owed.line_done, owed.field_byte, owed.field_length,
                        owed.length_saturated, line_done, field_byte, field_length,
                        length_saturated));
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic push_beat(input logic [BYTE_W-1:0] value, input logic eod);
        text_beat_t beat;
        beat.value = value;
        beat.eod = eod;
        pending_beats.push_back(beat);
    endtask

    task automatic push_text(input string text);
        for (int i = 0; i < text.len(); i++)
            push_beat(text[i], 1'b0);
    endtask

    // A byte that may sit inside a field: anything but the separators and end marks,
    // with the odd embedded space.
    function automatic logic [BYTE_W-1:0] field_char();
        logic [BYTE_W-1:0] value;
        if ($urandom_range(0, 9) == 0)
            return CHAR_SPACE;
        do
            value = BYTE_W'($urandom_range(0, 255));
        while (value == CHAR_NUL || value == CHAR_CR || value == CHAR_LF ||
               value == CHAR_COMMA);
        return value;
    endfunction

    // Mostly well-formed lines with random content and every kind of line end;
    // about one beat source in ten is a raw byte that may break a line anywhere.
    task automatic queue_random_text(input int unsigned beats);
        int unsigned start;
        int unsigned columns;
        start = pending_beats.size();
        while (pending_beats.size() - start < beats)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                push_beat(BYTE_W'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
            end
            else
            begin
                repeat ($urandom_range(0, 2)) push_beat(CHAR_SPACE, 1'b0);
                columns = $urandom_range(1, 5);
                for (int c = 0; c < columns; c++)
                begin
                    if (c != 0)
                        push_beat(CHAR_COMMA, 1'b0);
                    repeat ($urandom_range(0, 6)) push_beat(field_char(), 1'b0);
                end
                case ($urandom_range(0, 4))
                    0: push_beat(CHAR_LF, 1'b0);
                    1:
                    begin
                        push_beat(CHAR_CR, 1'b0);
                        push_beat(CHAR_LF, 1'b0);
                    end
                    2: push_beat(CHAR_CR, 1'b0);
                    3: push_beat(CHAR_NUL, 1'b0);
                    default: push_beat(BYTE_W'($urandom_range(0, 255)), 1'b1);
                endcase
            end
        end
    endtask

    // Waits until the sender is empty and every owed result has been seen, then
    // lets the block settle so a register write finds it idle.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_beats.size() != 0 || in_valid || field_results_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_target(input logic [COLUMN_W-1:0] column);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= column;
        target_now = column;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        logic [COLUMN_W-1:0] targets[5];
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed lines at the reset target, column 0. End marks and blanks
        // between lines do nothing; the data byte under end_of_data is ignored.
        push_beat(8'h41, 1'b1);
        push_beat(CHAR_NUL, 1'b0);
        push_text(" \r\n");
        push_beat(8'hFF, 1'b0);
        push_text(",q\r\n");
        wait_drained();

        // Column 1: a line that opens with a comma, a space inside the field, an
        // end_of_data beat whose byte is a comma, an empty target field, a line
        // too short to reach the target, and a line cut by end_of_data at once.
        write_target(16'd1);
        push_text(",x ");
        push_beat(CHAR_COMMA, 1'b1);
        push_text("a,");
        push_beat(CHAR_NUL, 1'b0);
        push_text("b\n");
        push_text("c,");
        push_beat(8'hFF, 1'b1);
        wait_drained();

        // Long single-column lines at column 0 while the receiver holds off for a
        // long stretch, so the result queue fills and the input has to stall.
        // Length saturation needs some sixteen million bytes in one field and is
        // left to the length comparison staying exact everywhere else.
        write_target(16'd0);
        repeat (6)
        begin
            repeat ($urandom_range(10, 40)) push_beat(field_char(), 1'b0);
            push_beat(CHAR_LF, 1'b0);
        end
        @(negedge clk);
        hold_requests++;
        wait_drained();

        // Random text at a handful of targets; every phase drains before the
        // next register write, which also gives the sender a full pause.
        targets[0] = 16'd1;
        targets[1] = 16'd2;
        targets[2] = 16'd0;
        targets[3] = 16'd3;
        targets[4] = COLUMN_W'($urandom_range(0, 4));
        foreach (targets[i])
        begin
            write_target(targets[i]);
            queue_random_text(40);
            if (i == 2)
            begin
                @(negedge clk);
                hold_requests++;
            end
            wait_drained();
        end

        if (error_count == 0 && field_results_due.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
